[design/lap_pkg.sv]
package lap_pkg;

  // default screen geometry and near plane (Q16.16)
  localparam int H_RES_DEF     = 640;
  localparam int V_RES_DEF     = 480;
  localparam int NEAR_DIST_DEF = 6554;

  // unit axis components, Q1.28 in a signed word
  localparam int AXIS_W = 30;

  // register indexes
  localparam logic [2:0] REG_CAM_X = 3'd0;
  localparam logic [2:0] REG_CAM_Y = 3'd1;
  localparam logic [2:0] REG_CAM_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X = 3'd3;
  localparam logic [2:0] REG_DIR_Y = 3'd4;
  localparam logic [2:0] REG_DIR_Z = 3'd5;
  localparam logic [2:0] REG_FAR   = 3'd6;
  localparam logic [2:0] REG_FOCAL = 3'd7;

  // reset values
  localparam logic [15:0] DIR_Z_RESET = 16'hF000;
  localparam logic [30:0] FAR_RESET   = 31'd209715200;
  localparam logic [15:0] FOCAL_RESET = 16'd256;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } point_t;

  typedef struct packed {
    logic signed [15:0] pixel_x;
    logic signed [15:0] pixel_y;
    logic               status;
  } pixel_t;

  // camera basis, rows right, up, forward
  typedef struct packed {
    logic                        ok;
    logic [2:0][AXIS_W-1:0]      rt;
    logic [2:0][AXIS_W-1:0]      up;
    logic [2:0][AXIS_W-1:0]      fwd;
  } basis_t;

  // numerators and denominator of the perspective divide
  typedef struct packed {
    logic               rej;
    logic signed [63:0] num_x;
    logic signed [63:0] num_y;
    logic [39:0]        den;
  } num_t;

endpackage

[design/look_at_perspective_projection.sv]
// Look-at perspective projection: each transfer on the point channel carries a world-space
// point (Q16.16) and yields one transfer on the pixel channel with its screen column, row
// (growing downward) and a status bit, 1 when the depth falls outside the near/far range or
// the camera direction is degenerate. One point per clock is taken unless the point channel is
// stalled; results pass the multiply stages and a 16 stage divider, one quotient bit per stage.
// After reset and after every write of a direction register the camera basis is rebuilt by a
// sequencer with one shared multiplier, square root and divider; while it runs the point
// channel is stalled; camera position, far distance and focal scale take effect at once.
module look_at_perspective_projection #(
  parameter int H_RES         = lap_pkg::H_RES_DEF,
  parameter int V_RES         = lap_pkg::V_RES_DEF,
  parameter int NEAR_DIST_Q16 = lap_pkg::NEAR_DIST_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [4:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready,
  input  logic            point_valid,
  output logic            point_stall,
  input  lap_pkg::point_t point,
  output logic            pixel_valid,
  input  logic            pixel_stall,
  output lap_pkg::pixel_t pixel
);
  import lap_pkg::*;

  logic [31:0] cam_x, cam_y, cam_z;
  logic [15:0] dir_x, dir_y, dir_z;
  logic [30:0] far_dist;
  logic [15:0] focal;
  logic        wr, dir_wr, busy, ready, take, num_valid, num_ready;
  logic [2:0]  ridx;
  basis_t      basis;
  num_t        num;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;
  assign ridx   = paddr[4:2];
  assign dir_wr = wr && (ridx == REG_DIR_X || ridx == REG_DIR_Y || ridx == REG_DIR_Z);

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cam_x    <= '0;
      cam_y    <= '0;
      cam_z    <= '0;
      dir_x    <= '0;
      dir_y    <= '0;
      dir_z    <= DIR_Z_RESET;
      far_dist <= FAR_RESET;
      focal    <= FOCAL_RESET;
    end else if (wr) begin
      case (ridx)
        REG_CAM_X: cam_x    <= pwdata;
        REG_CAM_Y: cam_y    <= pwdata;
        REG_CAM_Z: cam_z    <= pwdata;
        REG_DIR_X: dir_x    <= pwdata[15:0];
        REG_DIR_Y: dir_y    <= pwdata[15:0];
        REG_DIR_Z: dir_z    <= pwdata[15:0];
        REG_FAR:   far_dist <= pwdata[30:0];
        REG_FOCAL: focal    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register read
  always_comb begin
    case (ridx)
      REG_CAM_X: prdata = cam_x;
      REG_CAM_Y: prdata = cam_y;
      REG_CAM_Z: prdata = cam_z;
      REG_DIR_X: prdata = {16'b0, dir_x};
      REG_DIR_Y: prdata = {16'b0, dir_y};
      REG_DIR_Z: prdata = {16'b0, dir_z};
      REG_FAR:   prdata = {1'b0, far_dist};
      REG_FOCAL: prdata = {16'b0, focal};
      default:   prdata = '0;
    endcase
  end

  // camera basis
  lap_axis u_axis (
    .clk   (clk),
    .rst   (rst),
    .start (dir_wr),
    .dir_x (dir_x),
    .dir_y (dir_y),
    .dir_z (dir_z),
    .busy  (busy),
    .basis (basis)
  );

  assign point_stall = !ready || busy;
  assign take        = point_valid && !point_stall;

  // transform to camera space and form the divide operands
  lap_xform #(
    .HRes     (H_RES),
    .VRes     (V_RES),
    .NearDist (NEAR_DIST_Q16)
  ) u_xform (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .ready     (ready),
    .point     (point),
    .basis     (basis),
    .cam_x     (cam_x),
    .cam_y     (cam_y),
    .cam_z     (cam_z),
    .far_dist  (far_dist),
    .focal     (focal),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num)
  );

  // perspective divide and pixel output
  lap_div u_div (
    .clk         (clk),
    .rst         (rst),
    .num_valid   (num_valid),
    .num_ready   (num_ready),
    .num         (num),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel)
  );

`ifndef ASSERT_OFF
  // a direction write holds off points while the basis is rebuilt
  a_dir_hold: assert property (@(posedge clk) disable iff (rst)
    dir_wr |=> point_stall)
    else $error("point taken right after a direction write");

  // a rejected point carries zero pixels
  a_rej_zero: assert property (@(posedge clk) disable iff (rst)
    pixel_valid && pixel.status |-> pixel.pixel_x == 16'sd0 && pixel.pixel_y == 16'sd0)
    else $error("rejected point with nonzero pixels");

  // the basis only becomes usable at the end of a setup run
  a_basis_ok: assert property (@(posedge clk) disable iff (rst)
    $rose(basis.ok) |-> $past(busy))
    else $error("basis valid without setup");
`endif

endmodule

[design/lap_axis.sv]
module lap_axis (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [15:0]     dir_x,
  input  logic [15:0]     dir_y,
  input  logic [15:0]     dir_z,
  output logic            busy,
  output lap_pkg::basis_t basis
);
  import lap_pkg::*;

  typedef enum logic [5:0] {
    A_IDLE = 6'b000001,
    A_SUM  = 6'b000010,
    A_SQRT = 6'b000100,
    A_DIV  = 6'b001000,
    A_EPS  = 6'b010000,
    A_UP   = 6'b100000
  } ast_t;

  localparam logic [63:0] EPS_SQ = 64'd72058;

  ast_t                     state;
  logic [2:0]               idx;
  logic [5:0]               cnt;
  logic                     pass;
  logic                     ok;
  logic signed [63:0]       acc;
  logic [63:0]              rad;
  logic [63:0]              root;
  logic [31:0]              nrm;
  logic [57:0]              dq;
  logic [31:0]              rem;
  logic                     neg;
  logic signed [AXIS_W-1:0] fwd [3];
  logic signed [AXIS_W-1:0] rt0 [3];
  logic signed [AXIS_W-1:0] rt  [3];
  logic signed [AXIS_W-1:0] up  [3];

  logic signed [30:0] dirs [3];
  logic signed [30:0] ma, mb;
  logic signed [61:0] prod;
  logic signed [63:0] acc_sum, acc_dif;
  logic [1:0]         i1, i2, k;
  logic [63:0]        bsq, rb, root_next, rad_next;
  logic               ge_s;
  logic [32:0]        trial, dif;
  logic               gd;
  logic [57:0]        qn, qs;
  logic signed [30:0] srcv, mag;

  assign dirs[0] = {{15{dir_x[15]}}, dir_x};
  assign dirs[1] = {{15{dir_y[15]}}, dir_y};
  assign dirs[2] = {{15{dir_z[15]}}, dir_z};

  // cross product term indexes for the up axis
  assign k = idx[2:1];
  always_comb begin
    case (k)
      2'd0: begin i1 = 2'd1; i2 = 2'd2; end
      2'd1: begin i1 = 2'd2; i2 = 2'd0; end
      default: begin i1 = 2'd0; i2 = 2'd1; end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      A_SUM: begin
        ma = pass ? {rt0[idx[1:0]][AXIS_W-1], rt0[idx[1:0]]} : dirs[idx[1:0]];
        mb = ma;
      end
      A_EPS: begin
        ma = idx[0] ? {fwd[0][AXIS_W-1], fwd[0]} : {fwd[2][AXIS_W-1], fwd[2]};
        mb = ma;
      end
      A_UP: begin
        ma = idx[0] ? {fwd[i2][AXIS_W-1], fwd[i2]} : {fwd[i1][AXIS_W-1], fwd[i1]};
        mb = idx[0] ? {rt[i1][AXIS_W-1], rt[i1]} : {rt[i2][AXIS_W-1], rt[i2]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod    = ma * mb;
  assign acc_sum = acc + prod;
  assign acc_dif = acc - prod;

  // one bit of the integer square root
  assign bsq       = 64'(1) << {cnt[4:0], 1'b0};
  assign rb        = root + bsq;
  assign ge_s      = rad >= rb;
  assign root_next = ge_s ? (root >> 1) + bsq : root >> 1;
  assign rad_next  = ge_s ? rad - rb : rad;

  // one bit of the restoring divide
  assign trial = {rem, dq[57]};
  assign gd    = trial >= {1'b0, nrm};
  assign dif   = trial - {1'b0, nrm};
  assign qn    = {dq[56:0], gd};
  assign qs    = neg ? -qn : qn;

  // dividend source and magnitude
  assign srcv = pass ? {rt0[idx[1:0]][AXIS_W-1], rt0[idx[1:0]]} : dirs[idx[1:0]];
  assign mag  = srcv[30] ? -srcv : srcv;

  // setup sequencer
  always_ff @(posedge clk) begin
    if (rst || start) begin
      state <= A_SUM;
      idx   <= '0;
      cnt   <= '0;
      pass  <= 1'b0;
      ok    <= 1'b0;
      acc   <= '0;
    end else begin
      case (state)
        A_SUM: begin
          acc <= acc_sum;
          idx <= idx + 3'd1;
          if (idx == 3'd2) begin
            rad   <= pass ? acc_sum : acc_sum << 28;
            root  <= '0;
            cnt   <= 6'd31;
            state <= A_SQRT;
          end
        end
        A_SQRT: begin
          rad  <= rad_next;
          root <= root_next;
          if (cnt == 6'd0) begin
            nrm <= root_next[31:0];
            idx <= '0;
            cnt <= '0;
            if (root_next == 64'd0) begin
              state <= A_IDLE;
            end else begin
              state <= A_DIV;
            end
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        A_DIV: begin
          if (cnt == 6'd0) begin
            dq  <= pass ? {27'b0, mag} << 28 : {27'b0, mag} << 42;
            rem <= '0;
            neg <= srcv[30];
            cnt <= 6'd1;
          end else begin
            dq  <= qn;
            rem <= gd ? dif[31:0] : trial[31:0];
            if (cnt == 6'd58) begin
              if (pass) begin
                rt[idx[1:0]] <= qs[AXIS_W-1:0];
              end else begin
                fwd[idx[1:0]] <= qs[AXIS_W-1:0];
              end
              cnt <= '0;
              if (idx == 3'd2) begin
                idx   <= '0;
                acc   <= '0;
                state <= pass ? A_UP : A_EPS;
              end else begin
                idx <= idx + 3'd1;
              end
            end else begin
              cnt <= cnt + 6'd1;
            end
          end
        end
        A_EPS: begin
          if (idx[0]) begin
            // nearly vertical forward axis picks the alternate reference
            if (acc_sum < $signed(EPS_SQ)) begin
              rt0[0] <= -fwd[1];
              rt0[1] <= fwd[0];
              rt0[2] <= '0;
            end else begin
              rt0[0] <= fwd[2];
              rt0[1] <= '0;
              rt0[2] <= -fwd[0];
            end
            pass  <= 1'b1;
            idx   <= '0;
            acc   <= '0;
            state <= A_SUM;
          end else begin
            acc <= acc_sum;
            idx <= idx + 3'd1;
          end
        end
        A_UP: begin
          idx <= idx + 3'd1;
          if (!idx[0]) begin
            acc <= 64'(prod);
          end else begin
            up[k] <= acc_dif[57:28];
          end
          if (idx == 3'd5) begin
            ok    <= 1'b1;
            state <= A_IDLE;
          end
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != A_IDLE);

  always_comb begin
    basis.ok = ok;
    for (int i = 0; i < 3; i++) begin
      basis.rt[i]  = rt[i];
      basis.up[i]  = up[i];
      basis.fwd[i] = fwd[i];
    end
  end

endmodule

[design/lap_xform.sv]
module lap_xform #(
  parameter int HRes     = lap_pkg::H_RES_DEF,
  parameter int VRes     = lap_pkg::V_RES_DEF,
  parameter int NearDist = lap_pkg::NEAR_DIST_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            take,
  output logic            ready,
  input  lap_pkg::point_t point,
  input  lap_pkg::basis_t basis,
  input  logic [31:0]     cam_x,
  input  logic [31:0]     cam_y,
  input  logic [31:0]     cam_z,
  input  logic [30:0]     far_dist,
  input  logic [15:0]     focal,
  output logic            num_valid,
  input  logic            num_ready,
  output lap_pkg::num_t   num
);
  import lap_pkg::*;

  localparam logic [20:0]        KW   = 21'(256 * HRes);
  localparam logic [20:0]        KH   = 21'(256 * VRes);
  localparam logic signed [13:0] HC   = 14'(VRes);
  localparam logic signed [36:0] NEAR = 37'(NearDist);
  localparam logic signed [36:0] LIM  = 37'(64'd1 << 34);

  logic [7:1] v, en;

  logic signed [32:0]       d [3];
  logic signed [62:0]       p [3][3];
  logic signed [36:0]       c3 [3];
  logic signed [35:0]       x4, y4;
  logic [30:0]              z4, z5, z6;
  logic                     rj4, rj5, rj6;
  logic signed [52:0]       xf5, yf5;
  logic [51:0]              zw5, zh5, zw6, zh6;
  logic signed [63:0]       xfh6, yfh6;
  logic signed [AXIS_W-1:0] ax [3][3];
  logic signed [64:0]       sum [3];

  // enable chain, a stage moves when empty or when its successor moves
  assign en[7] = !v[7] || num_ready;
  assign en[6] = !v[6] || en[7];
  assign en[5] = !v[5] || en[6];
  assign en[4] = !v[4] || en[5];
  assign en[3] = !v[3] || en[4];
  assign en[2] = !v[2] || en[3];
  assign en[1] = !v[1] || en[2];
  assign ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= take;
      for (int s = 2; s <= 7; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      ax[0][c] = $signed(basis.rt[c]);
      ax[1][c] = $signed(basis.up[c]);
      ax[2][c] = $signed(basis.fwd[c]);
    end
    for (int r = 0; r < 3; r++) begin
      sum[r] = p[r][0] + p[r][1] + p[r][2];
    end
  end

  // offset from the camera
  always_ff @(posedge clk) begin
    if (en[1]) begin
      d[0] <= {point.world_x[31], point.world_x} - {cam_x[31], cam_x};
      d[1] <= {point.world_y[31], point.world_y} - {cam_y[31], cam_y};
      d[2] <= {point.world_z[31], point.world_z} - {cam_z[31], cam_z};
    end
  end

  // axis products
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p[r][c] <= d[c] * ax[r][c];
        end
      end
    end
  end

  // dot products floored to Q16.16
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        c3[r] <= sum[r][64:28];
      end
    end
  end

  // depth test and clamp of the lateral coordinates
  always_ff @(posedge clk) begin
    if (en[4]) begin
      x4  <= (c3[0] > LIM) ? LIM[35:0] : (c3[0] < -LIM) ? 36'(-LIM) : c3[0][35:0];
      y4  <= (c3[1] > LIM) ? LIM[35:0] : (c3[1] < -LIM) ? 36'(-LIM) : c3[1][35:0];
      z4  <= c3[2][30:0];
      rj4 <= !basis.ok || !(c3[2] > NEAR && c3[2] < $signed({6'b0, far_dist}));
    end
  end

  // focal scale and depth terms
  always_ff @(posedge clk) begin
    if (en[5]) begin
      xf5 <= x4 * $signed({1'b0, focal});
      yf5 <= y4 * $signed({1'b0, focal});
      zw5 <= z4 * KW;
      zh5 <= z4 * KH;
      z5  <= z4;
      rj5 <= rj4;
    end
  end

  // screen height term
  always_ff @(posedge clk) begin
    if (en[6]) begin
      xfh6 <= xf5 * HC;
      yfh6 <= yf5 * HC;
      zw6  <= zw5;
      zh6  <= zh5;
      z6   <= z5;
      rj6  <= rj5;
    end
  end

  // numerators and denominator
  always_ff @(posedge clk) begin
    if (en[7]) begin
      num.num_x <= $signed({12'b0, zw6}) + xfh6;
      num.num_y <= $signed({12'b0, zh6}) - yfh6;
      num.den   <= {z6, 9'b0};
      num.rej   <= rj6;
    end
  end

  assign num_valid = v[7];

endmodule

[design/lap_div.sv]
module lap_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            num_valid,
  output logic            num_ready,
  input  lap_pkg::num_t   num,
  output logic            pixel_valid,
  input  logic            pixel_stall,
  output lap_pkg::pixel_t pixel
);
  import lap_pkg::*;

  localparam int QW = 16;

  typedef struct packed {
    logic [55:0]   rem_x;
    logic [55:0]   rem_y;
    logic [QW-1:0] q_x;
    logic [QW-1:0] q_y;
    logic          neg_x;
    logic          neg_y;
    logic          ovf_x;
    logic          ovf_y;
    logic          rej;
    logic [39:0]   den;
  } dstage_t;

  logic [QW+1:0] v, en;
  dstage_t       st [QW+1];
  logic [63:0]   mag_x, mag_y;

  function automatic logic [15:0] fmt(input logic [QW-1:0] q, input logic neg,
                                      input logic ovf, input logic rej);
    logic [15:0] r;
    if (rej) begin
      r = '0;
    end else if (!neg) begin
      r = (ovf || q >= 16'd32767) ? 16'h7FFF : q;
    end else begin
      r = (ovf || q[QW-1]) ? 16'h8000 : -q;
    end
    return r;
  endfunction

  // enable chain
  assign en[QW+1] = !v[QW+1] || !pixel_stall;
  for (genvar j = 0; j <= QW; j++) begin : g_en
    assign en[j] = !v[j] || en[j+1];
  end
  assign num_ready = en[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) v[0] <= num_valid;
      for (int s = 1; s <= QW + 1; s++) begin
        if (en[s]) v[s] <= v[s-1];
      end
    end
  end

  // magnitudes and overflow against the 16 bit quotient range
  assign mag_x = num.num_x[63] ? -num.num_x : num.num_x;
  assign mag_y = num.num_y[63] ? -num.num_y : num.num_y;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0].rem_x <= mag_x[55:0];
      st[0].rem_y <= mag_y[55:0];
      st[0].q_x   <= '0;
      st[0].q_y   <= '0;
      st[0].neg_x <= num.num_x[63];
      st[0].neg_y <= num.num_y[63];
      st[0].ovf_x <= mag_x >= {8'b0, num.den, 16'b0};
      st[0].ovf_y <= mag_y >= {8'b0, num.den, 16'b0};
      st[0].rej   <= num.rej;
      st[0].den   <= num.den;
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 1; j <= QW; j++) begin : g_bit
    localparam int K = QW - j;
    logic [55:0] dsh;
    logic        gx, gy;
    dstage_t     nxt;
    assign dsh = {16'b0, st[j-1].den} << K;
    assign gx  = st[j-1].rem_x >= dsh;
    assign gy  = st[j-1].rem_y >= dsh;
    // stage contents with the new remainders and quotient bit
    always_comb begin
      nxt        = st[j-1];
      nxt.rem_x  = gx ? st[j-1].rem_x - dsh : st[j-1].rem_x;
      nxt.rem_y  = gy ? st[j-1].rem_y - dsh : st[j-1].rem_y;
      nxt.q_x[K] = gx;
      nxt.q_y[K] = gy;
    end
    always_ff @(posedge clk) begin
      if (en[j]) begin
        st[j] <= nxt;
      end
    end
  end

  // sign, saturation and output register
  always_ff @(posedge clk) begin
    if (en[QW+1]) begin
      pixel.pixel_x <= fmt(st[QW].q_x, st[QW].neg_x, st[QW].ovf_x, st[QW].rej);
      pixel.pixel_y <= fmt(st[QW].q_y, st[QW].neg_y, st[QW].ovf_y, st[QW].rej);
      pixel.status  <= st[QW].rej;
    end
  end

  assign pixel_valid = v[QW+1];

endmodule
